>>> src/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
// no dependencies

package u8d_pkg;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] MIN_FOUR    = 21'h010000;
    localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;

    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic [2:0]  byte_count;
        logic        last_of_run;
        logic        text_done;
    } t_out_word;

endpackage

>>> src/u8d_in_if.sv
// input byte channel of the utf-8 stream decoder
// depends on u8d_pkg

interface u8d_in_if
    import u8d_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/u8d_out_if.sv
// code point result channel of the utf-8 stream decoder
// depends on u8d_pkg

interface u8d_out_if
    import u8d_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/utf8_stream_decoder.sv
// Streaming UTF-8 decoder: one byte word in, zero to four code point words out.
// Bytes are appended to a four-byte working buffer; each cycle the head of the
// buffer is decoded and, unless the output stalls, one result is written to the
// output register. A byte that yields at most one result is taken every cycle
// while the output does not stall, going through the working buffer and then
// the output register; a byte that flushes k results (malformed data or end of
// text) holds off input until all k are written. A byte that only extends a
// pending sequence gives no word. Up to three undecided bytes are held between
// words. Depends on u8d_pkg, u8d_in_if and u8d_out_if.

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8d_in_if.sink       i_in,
    u8d_out_if.source    o_out
);

    typedef struct packed {
        logic        hold;
        logic        bad;
        logic [20:0] cp;
        logic [2:0]  adv;
    } t_dec;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic t_dec decode(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [2:0] len, input logic eot);
        t_dec        d;
        logic [2:0]  need;
        logic        broken;
        logic        short_seq;
        logic [20:0] v;
        logic        ok;
        need = 3'd1;
        if (b0[7:5] == 3'b110) begin
            need = 3'd2;
        end else if (b0[7:4] == 4'b1110) begin
            need = 3'd3;
        end else if (b0[7:3] == 5'b11110) begin
            need = 3'd4;
        end
        broken = (need >= 3'd2 && len >= 3'd2 && !is_cont(b1)) ||
                 (need >= 3'd3 && len >= 3'd3 && !is_cont(b2)) ||
                 (need == 3'd4 && len == 3'd4 && !is_cont(b3));
        short_seq = len < need;
        case (need)
            3'd2: begin
                v  = {10'd0, b0[4:0], b1[5:0]};
                ok = v >= MIN_TWO;
            end
            3'd3: begin
                v  = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                ok = v >= MIN_THREE && !(v >= SURR_LO && v <= SURR_HI);
            end
            3'd4: begin
                v  = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                ok = v >= MIN_FOUR && v <= MAX_SCALAR;
            end
            default: begin
                v  = '0;
                ok = 1'b0;
            end
        endcase
        d.hold = need > 3'd1 && !broken && short_seq && !eot;
        d.bad  = 1'b1;
        d.cp   = REPLACEMENT;
        d.adv  = 3'd1;
        if (!b0[7]) begin
            d.bad = 1'b0;
            d.cp  = {13'd0, b0};
        end else if (need > 3'd1 && !broken && !short_seq && ok) begin
            d.bad = 1'b0;
            d.cp  = v;
            d.adv = need;
        end
        return d;
    endfunction

    logic [7:0] r_buf [4];
    logic [7:0] n_buf [4];
    logic [2:0] r_len, n_len;
    logic       r_eot, n_eot;
    logic       r_active, n_active;
    logic       r_out_valid, n_out_valid;
    t_out_word  r_out, n_out;

    logic [7:0] sh [4];
    logic [7:0] base [4];
    logic [2:0] base_len;
    logic [2:0] rem;
    t_dec       dec, dec2;
    logic       emit, out_ok, fire, last, finish, accept;

    always_comb begin
        dec = decode(r_buf[0], r_buf[1], r_buf[2], r_buf[3], r_len, r_eot);
        case (dec.adv)
            3'd1:    begin sh[0] = r_buf[1]; sh[1] = r_buf[2]; sh[2] = r_buf[3]; sh[3] = '0; end
            3'd2:    begin sh[0] = r_buf[2]; sh[1] = r_buf[3]; sh[2] = '0;       sh[3] = '0; end
            3'd3:    begin sh[0] = r_buf[3]; sh[1] = '0;       sh[2] = '0;       sh[3] = '0; end
            default: begin sh[0] = '0;       sh[1] = '0;       sh[2] = '0;       sh[3] = '0; end
        endcase
        rem    = r_len - dec.adv;
        dec2   = decode(sh[0], sh[1], sh[2], sh[3], rem, r_eot);
        last   = (rem == 3'd0) || dec2.hold;
        emit   = r_active && !dec.hold;
        out_ok = !r_out_valid || o_out.ready;
        fire   = emit && out_ok;
        finish = r_active && (dec.hold || (fire && last));
    end

    assign i_in.ready  = !r_active || finish;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        if (fire) begin
            base     = sh;
            base_len = rem;
        end else begin
            base     = r_buf;
            base_len = r_len;
        end
        n_buf    = base;
        n_len    = base_len;
        n_eot    = r_eot;
        n_active = r_active;
        if (accept) begin
            n_buf[base_len[1:0]] = i_in.data.byte_value;
            n_len    = base_len + 3'd1;
            n_eot    = i_in.data.end_of_text;
            n_active = 1'b1;
        end else if (finish) begin
            n_active = 1'b0;
        end
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out.code_point  = dec.cp;
            n_out.malformed   = dec.bad;
            n_out.byte_count  = dec.adv;
            n_out.last_of_run = last;
            n_out.text_done   = last && r_eot;
            n_out_valid       = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
        r_buf <= n_buf;
        r_eot <= n_eot;
        r_out <= n_out;
    end

    a_idle_held_le3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_len <= 3'd3)
        else $error("more than three bytes held while idle");

    a_eot_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && r_eot && !accept) |=> r_len == 3'd0)
        else $error("bytes left held after end of text");

    a_bad_is_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.malformed) |->
            (o_out.data.code_point == REPLACEMENT && o_out.data.byte_count == 3'd1))
        else $error("malformed word without replacement code point");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while a pending result is stalled");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (!r_out.text_done || r_out.last_of_run))
        else $error("text done flagged on a word that is not last of its run");

endmodule
